// ----- hdl/page_table_map_engine_top_assert.svh -----
// Assertion macros used by the page table map engine sequencer (ptme_ctrl).
`ifndef PAGE_TABLE_MAP_ENGINE_TOP_ASSERT_SVH
`define PAGE_TABLE_MAP_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and switched off while in reset.
`define PTME_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and switched off while in reset.
`define PTME_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/ptme_pkg.sv -----
// Package of types, constants and helpers for the page table map engine.
package ptme_pkg;

  // Sizes of the page tables and of the pool.
  localparam int POOL_TABLES   = 16;
  localparam int DIR_ENTRIES   = 1024;
  localparam int TABLE_ENTRIES = 1024;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int POOL_IW       = (POOL_TABLES > 1) ? $clog2(POOL_TABLES) : 1;
  localparam int SLOT_IW       = $clog2(POOL_TABLES + 1);
  localparam int POOL_DEPTH    = POOL_TABLES * TABLE_ENTRIES;
  localparam int PAGE_SHIFT    = 12;
  localparam int OUT_SLOT_W    = 5;

  // Fixed directory and table positions.
  localparam logic [IDX_W-1:0] FIRST_IDX       = '0;
  localparam logic [IDX_W-1:0] LAST_IDX        = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [IDX_W-1:0] KERNEL_HALF_DIR = IDX_W'(768);
  localparam logic [IDX_W-1:0] VGA_SLOT        = IDX_W'(1023);
  localparam logic [31:0]      VGA_PHYS        = 32'h000B_8000;

  // Entry flags.
  localparam logic [31:0] FLAG_PRESENT  = 32'h0000_0001;
  localparam logic [31:0] FLAG_WRITABLE = 32'h0000_0002;
  localparam logic [31:0] FLAGS_PW      = FLAG_PRESENT | FLAG_WRITABLE;

  // Request and status codes.
  localparam logic REQ_INIT         = 1'b0;
  localparam logic REQ_MAP          = 1'b1;
  localparam logic STATUS_DONE      = 1'b0;
  localparam logic STATUS_EXHAUSTED = 1'b1;

  // Register map: two 32-bit registers at byte addresses 0 and 4.
  localparam int   CFG_AW          = 3;
  localparam logic REG_FIRST_TABLE = 1'b0;
  localparam logic REG_POOL_BASE   = 1'b1;

  // Input word.
  typedef struct packed {
    logic        req_type;
    logic [31:0] virt_addr;
    logic [31:0] phys_addr;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic                  status;
    logic                  table_allocated;
    logic [31:0]           dir_entry;
    logic [31:0]           table_entry;
    logic [OUT_SLOT_W-1:0] table_slot;
  } out_word_t;

  // One directory record: the entry and the table it points at.
  typedef struct packed {
    logic [31:0]        entry;
    logic [SLOT_IW-1:0] slot;
  } dir_rec_t;

  localparam int DIR_W = $bits(dir_rec_t);

  // Operands for the shared adder.
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
  } add_op_t;

  // Table slot number of pool table k.
  function automatic logic [SLOT_IW-1:0] slot_of(input logic [POOL_IW-1:0] k);
    logic [31:0] s;
    s = 32'(k) + 32'd1;
    return s[SLOT_IW-1:0];
  endfunction

  // Slot number as reported on the result word, kept to five bits.
  function automatic logic [OUT_SLOT_W-1:0] out_slot(input logic [SLOT_IW-1:0] s);
    logic [31:0] w;
    w = 32'(s);
    return w[OUT_SLOT_W-1:0];
  endfunction

endpackage

// ----- hdl/ptme_ram.sv -----
// Generic single-port-write, registered-read RAM.
module ptme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/ptme_alu.sv -----
// Shared 32-bit adder used for sweep counting and pool address generation.
module ptme_alu (
  input  ptme_pkg::add_op_t op,
  output logic [31:0]       sum
);

  import ptme_pkg::*;

  // Modulo 2^32 sum, so pool addresses wrap as the address space does.
  assign sum = op.a + op.b;

endmodule

// ----- hdl/ptme_ctrl.sv -----
// Sequencer, table memories and result register of the page table map engine.
`include "page_table_map_engine_top_assert.svh"

module ptme_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [31:0]        first_table_phys,
  input  logic [31:0]        pool_phys_base,
  input  logic               in_valid,
  output logic               in_stall,
  input  ptme_pkg::in_word_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ptme_pkg::out_word_t out_data
);

  import ptme_pkg::*;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DRD  = 3'd1;
  localparam logic [2:0] ST_SRCH = 3'd2;
  localparam logic [2:0] ST_FILL = 3'd3;
  localparam logic [2:0] ST_DWR  = 3'd4;
  localparam logic [2:0] ST_WR   = 3'd5;
  localparam logic [2:0] ST_INIT = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  logic [2:0]             state_r, state_nxt;
  in_word_t               req_r, req_nxt;
  logic [IDX_W-1:0]       cnt_r, cnt_nxt;
  logic [POOL_IW-1:0]     k_r, k_nxt;
  logic [POOL_TABLES-1:0] pool_used_r, pool_used_nxt;
  logic [31:0]            dir_r, dir_nxt;
  logic [SLOT_IW-1:0]     slot_r, slot_nxt;
  logic                   alloc_r, alloc_nxt;
  logic                   status_r, status_nxt;
  logic [31:0]            entry_r, entry_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_word_t              out_r, out_nxt;

  logic                   in_acc;
  logic                   out_free;
  logic [IDX_W-1:0]       di;
  logic [IDX_W-1:0]       ti;
  logic [SLOT_IW-1:0]     slot_m1;
  logic [31:0]            init_dir_val;

  // Memory ports.
  logic                     dir_we;
  logic [IDX_W-1:0]         dir_waddr;
  dir_rec_t                 dir_wdata;
  logic [IDX_W-1:0]         dir_raddr;
  dir_rec_t                 dir_rdata;
  logic                     id_we;
  logic [IDX_W-1:0]         id_waddr;
  logic [31:0]              id_wdata;
  logic                     pool_we;
  logic [POOL_IW+IDX_W-1:0] pool_waddr;
  logic [31:0]              pool_wdata;

  // Shared adder.
  add_op_t     add_op;
  logic [31:0] add_sum;

  ptme_alu u_alu (
    .op  (add_op),
    .sum (add_sum)
  );

  // Directory with the table slot of each entry.
  ptme_ram #(.WIDTH(DIR_W), .DEPTH(DIR_ENTRIES)) u_dir_ram (
    .clk   (clk),
    .we    (dir_we),
    .waddr (dir_waddr),
    .wdata (dir_wdata),
    .raddr (dir_raddr),
    .rdata (dir_rdata)
  );

  // Identity page table; written only.
  ptme_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_id_ram (
    .clk   (clk),
    .we    (id_we),
    .waddr (id_waddr),
    .wdata (id_wdata),
    .raddr ('0),
    .rdata ()
  );

  // Pool of page tables, one 1024-word row per table; written only.
  ptme_ram #(.WIDTH(32), .DEPTH(POOL_DEPTH)) u_pool_ram (
    .clk   (clk),
    .we    (pool_we),
    .waddr (pool_waddr),
    .wdata (pool_wdata),
    .raddr ('0),
    .rdata ()
  );

  // Handshake and address split.
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign di        = req_r.virt_addr[31:22];
  assign ti        = req_r.virt_addr[21:12];
  assign slot_m1   = slot_r - SLOT_IW'(1);
  assign dir_raddr = in_data.virt_addr[31:22];

  // Directory entry that init leaves at the requested index.
  assign init_dir_val = (di == FIRST_IDX || di == KERNEL_HALF_DIR) ?
                        (first_table_phys | FLAGS_PW) : FLAG_WRITABLE;

  // Shared adder operands: pool table address while searching, else counter step.
  always_comb begin
    if (state_r == ST_SRCH) begin
      add_op.a = pool_phys_base;
      add_op.b = 32'(k_r) << PAGE_SHIFT;
    end else begin
      add_op.a = 32'(cnt_r);
      add_op.b = 32'd1;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    pool_used_nxt = pool_used_r;
    dir_nxt       = dir_r;
    slot_nxt      = slot_r;
    alloc_nxt     = alloc_r;
    status_nxt    = status_r;
    entry_nxt     = entry_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;

    dir_we     = 1'b0;
    dir_waddr  = di;
    dir_wdata  = '{entry: dir_r, slot: slot_r};
    id_we      = 1'b0;
    id_waddr   = ti;
    id_wdata   = req_r.phys_addr | FLAGS_PW;
    pool_we    = 1'b0;
    pool_waddr = {slot_m1[POOL_IW-1:0], ti};
    pool_wdata = req_r.phys_addr | FLAGS_PW;

    // The result word leaves when the consumer takes it.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          req_nxt    = in_data;
          cnt_nxt    = '0;
          alloc_nxt  = 1'b0;
          status_nxt = STATUS_DONE;
          entry_nxt  = '0;
          slot_nxt   = '0;
          state_nxt  = (in_data.req_type == REQ_INIT) ? ST_INIT : ST_DRD;
        end
      end
      ST_DRD: begin
        // Directory word is back from the RAM.
        dir_nxt  = dir_rdata.entry;
        slot_nxt = dir_rdata.slot;
        k_nxt    = '0;
        if ((dir_rdata.entry & FLAG_PRESENT) != '0) begin
          state_nxt = ST_WR;
        end else begin
          state_nxt = ST_SRCH;
        end
      end
      ST_SRCH: begin
        // One used flag is looked at per cycle, lowest first.
        if (!pool_used_r[k_r]) begin
          pool_used_nxt[k_r] = 1'b1;
          alloc_nxt          = 1'b1;
          dir_nxt            = add_sum | FLAGS_PW;
          slot_nxt           = slot_of(k_r);
          cnt_nxt            = '0;
          state_nxt          = ST_FILL;
        end else if (k_r == POOL_IW'(POOL_TABLES - 1)) begin
          status_nxt = STATUS_EXHAUSTED;
          state_nxt  = ST_DONE;
        end else begin
          k_nxt = k_r + POOL_IW'(1);
        end
      end
      ST_FILL: begin
        // Fresh pool table: every entry writable, not present.
        pool_we    = 1'b1;
        pool_waddr = {k_r, cnt_r};
        pool_wdata = FLAG_WRITABLE;
        cnt_nxt    = add_sum[IDX_W-1:0];
        if (cnt_r == LAST_IDX) begin
          state_nxt = ST_DWR;
        end
      end
      ST_DWR: begin
        dir_we    = 1'b1;
        state_nxt = ST_WR;
      end
      ST_WR: begin
        // Page table entry goes to the identity table or the pool table.
        entry_nxt = req_r.phys_addr | FLAGS_PW;
        if (slot_r == '0) begin
          id_we = 1'b1;
        end else if (32'(slot_r) <= POOL_TABLES) begin
          pool_we = 1'b1;
        end
        state_nxt = ST_DONE;
      end
      ST_INIT: begin
        // One directory entry and one identity entry per cycle.
        dir_we    = 1'b1;
        dir_waddr = cnt_r;
        if (cnt_r == FIRST_IDX || cnt_r == KERNEL_HALF_DIR) begin
          dir_wdata = '{entry: first_table_phys | FLAGS_PW, slot: '0};
        end else begin
          dir_wdata = '{entry: FLAG_WRITABLE, slot: '0};
        end
        id_we    = 1'b1;
        id_waddr = cnt_r;
        if (cnt_r == VGA_SLOT) begin
          id_wdata = VGA_PHYS | FLAGS_PW;
        end else begin
          id_wdata = (32'(cnt_r) << PAGE_SHIFT) | FLAGS_PW;
        end
        cnt_nxt = add_sum[IDX_W-1:0];
        if (cnt_r == LAST_IDX) begin
          dir_nxt   = init_dir_val;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_nxt.status          = status_r;
          out_nxt.table_allocated = alloc_r;
          out_nxt.dir_entry       = dir_r;
          out_nxt.table_entry     = entry_r;
          out_nxt.table_slot      = (status_r == STATUS_EXHAUSTED) ? '0 : out_slot(slot_r);
          state_nxt               = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pool_used_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pool_used_r <= pool_used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    cnt_r    <= cnt_nxt;
    k_r      <= k_nxt;
    dir_r    <= dir_nxt;
    slot_r   <= slot_nxt;
    alloc_r  <= alloc_nxt;
    status_r <= status_nxt;
    entry_r  <= entry_nxt;
    out_r    <= out_nxt;
  end

  // Checks on the sequencer.
  `PTME_ASSERT_NOW(a_exhaust_clean,
    out_valid_r && out_r.status == STATUS_EXHAUSTED,
    !out_r.table_allocated && out_r.table_entry == '0 && out_r.table_slot == '0,
    "exhausted result carries an allocation or a table entry")
  `PTME_ASSERT_NEXT(a_map_reads_dir,
    in_acc && in_data.req_type == REQ_MAP,
    state_r == ST_DRD,
    "map request did not go on to the directory read")
  `PTME_ASSERT_NOW(a_pool_write_state,
    pool_we,
    state_r == ST_FILL || state_r == ST_WR,
    "pool table written outside fill or entry write")
  `PTME_ASSERT_NOW(a_fill_owned,
    state_r == ST_FILL,
    pool_used_r[k_r],
    "pool table filled without its used flag")
  `PTME_ASSERT_NEXT(a_alloc_marks,
    state_r == ST_SRCH && !pool_used_r[k_r],
    $countones(pool_used_r) == $countones($past(pool_used_r)) + 1,
    "allocation did not take exactly one pool table")

endmodule

// ----- hdl/page_table_map_engine_top.sv -----
// Top level of the page table map engine: register port and sequencer.
//
//  Port group  Direction  Handshake              Word
//  in_*        input      in_valid / in_stall    in_word_t
//  out_*       output     out_valid / out_stall  out_word_t
//  p*          config     psel, penable, pready  32-bit registers at 0 and 4
//
// A map request to a present directory entry steps through accept, directory
// read, table write and result. Taking a pool table adds a search of the used
// flags, lowest first, then a fill of the table and the directory entry write.
// An init request sweeps the 1024 directory and identity entries.
// rst_n clears the sequencer, the pool used flags and the registers; the tables
// hold nothing defined until init. A stalled result waits in the result register.
module page_table_map_engine_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ptme_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  ptme_pkg::in_word_t           in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output ptme_pkg::out_word_t          out_data
);

  import ptme_pkg::*;

  logic [31:0] first_table_r, first_table_nxt;
  logic [31:0] pool_base_r, pool_base_nxt;
  logic        reg_wr;
  logic        reg_sel;

  // Register port: no wait states.
  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_comb begin
    first_table_nxt = first_table_r;
    pool_base_nxt   = pool_base_r;
    if (reg_wr) begin
      case (reg_sel)
        REG_FIRST_TABLE: first_table_nxt = pwdata;
        REG_POOL_BASE:   pool_base_nxt   = pwdata;
        default: begin
        end
      endcase
    end
  end

  // Read back.
  always_comb begin
    case (reg_sel)
      REG_FIRST_TABLE: prdata = first_table_r;
      REG_POOL_BASE:   prdata = pool_base_r;
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_table_r <= '0;
      pool_base_r   <= '0;
    end else begin
      first_table_r <= first_table_nxt;
      pool_base_r   <= pool_base_nxt;
    end
  end

  ptme_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .first_table_phys (first_table_r),
    .pool_phys_base   (pool_base_r),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_data         (out_data)
  );

endmodule
